@@ src/frms_pkg.sv @@
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package frms_pkg;

    // Field widths.
    localparam int STAMP_W    = 32;
    localparam int RATE_W     = 18;
    localparam int COEFF_W    = 16;
    localparam int WIN_W      = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Product plus product of the low-pass filter, before the shift by sixteen.
    localparam int ACC_W = RATE_W + COEFF_W + 1;

    // Default ring depth of the moving average.
    localparam int MAX_WINDOW_DEF = 16;

    // One thousand frames per second scaled to Q10.8.
    localparam int unsigned RATE_SCALE = 256000;

    // Register reset values.
    localparam logic [COEFF_W-1:0] LP_COEFF_RST   = 16'd52429;
    localparam logic [WIN_W-1:0]   AVG_WINDOW_RST = 5'd8;

    // Smoothing modes.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_COEFF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW  = 2'd2;

    // Request types.
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // capture the input beat
        logic clear_all;   // forget the stamp and empty the smoother
        logic res_zero;    // result is all zero
        logic stamp_store; // the new stamp becomes the previous stamp
        logic div1_load;   // start 256000 / interval
        logic div2_load;   // start ring sum / ring count
        logic div_step;    // one quotient bit
        logic raw_load;    // raw rate from the quotient
        logic sm_raw;      // smoothed rate equals raw rate
        logic seed;        // first sample seeds the low-pass filter
        logic mul1;        // old value times weight
        logic mul2;        // add new value times complement, update filter
        logic ev_rd;       // read the oldest ring entry
        logic ev_sub;      // drop the oldest ring entry from the sum
        logic ins;         // insert the raw rate into the ring
        logic sm_quot;     // smoothed rate from the quotient
        logic out_load;    // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              req_clear;
        logic              interval_ok;
        logic              div_done;
        logic [MODE_W-1:0] mode;
        logic              seeded;
        logic              evict_needed;
    } sts_t;

endpackage

`default_nettype wire

@@ src/frms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module frms_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/frms_dp.sv @@
// Datapath: stamp, shared divider, low-pass multiplier, averaging ring and result registers.
`timescale 1ns / 1ps
`default_nettype none

module frms_dp #(
    parameter int MAX_WINDOW = frms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire frms_pkg::cmd_t                    cmd,
    output frms_pkg::sts_t                         sts,
    input  wire logic                              req_type,
    input  wire logic [frms_pkg::STAMP_W-1:0]      frame_time,
    input  wire logic                              cfg_we,
    input  wire logic [frms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [frms_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic      [frms_pkg::RATE_W-1:0]       raw_rate,
    output logic      [frms_pkg::RATE_W-1:0]       smoothed_rate,
    output logic                                   rate_valid
);

    localparam int STAMP_W = frms_pkg::STAMP_W;
    localparam int RATE_W  = frms_pkg::RATE_W;
    localparam int COEFF_W = frms_pkg::COEFF_W;
    localparam int WIN_W   = frms_pkg::WIN_W;
    localparam int MODE_W  = frms_pkg::MODE_W;
    localparam int ACC_W   = frms_pkg::ACC_W;
    localparam int HEAD_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int OLD_W   = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int SUM_W   = RATE_W + $clog2(MAX_WINDOW);
    localparam int DCNT_W  = $clog2(SUM_W + 1);

    // Configuration registers.
    logic [MODE_W-1:0]  smooth_mode_reg;
    logic [COEFF_W-1:0] lp_coeff_reg;
    logic [WIN_W-1:0]   avg_window_reg;

    // Item state.
    logic                req_reg;
    logic [STAMP_W-1:0]  now_reg;
    logic [STAMP_W-1:0]  last_stamp_reg;

    // Smoother state.
    logic [RATE_W-1:0] filter_value_reg;
    logic              filter_seeded_reg;
    logic [HEAD_W-1:0] ring_head_reg;
    logic [CNT_W-1:0]  ring_count_reg;
    logic [SUM_W-1:0]  ring_sum_reg;

    // Divider.
    logic [SUM_W-1:0]   dq_reg;
    logic [STAMP_W-1:0] rem_reg;
    logic [STAMP_W-1:0] dvs_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [STAMP_W:0]   trial;
    logic [STAMP_W:0]   trial_diff;
    logic               trial_ge;

    // Multiplier.
    logic [ACC_W-1:0]   acc_reg;
    logic [RATE_W-1:0]  mul_a;
    logic [COEFF_W:0]   mul_b;
    logic [ACC_W-1:0]   prod;
    logic [ACC_W-1:0]   lp_sum;

    // Working result and output register.
    logic [RATE_W-1:0] raw_reg;
    logic [RATE_W-1:0] sm_reg;
    logic              ok_reg;
    logic [RATE_W-1:0] out_raw_reg;
    logic [RATE_W-1:0] out_sm_reg;
    logic              out_ok_reg;

    // Ring addressing.
    logic [OLD_W-1:0]  oldest_sum;
    logic [HEAD_W-1:0] oldest;
    logic [CMP_W-1:0]  win_ext;
    logic [CMP_W-1:0]  win_eff;
    logic [RATE_W-1:0] ram_rdata;
    logic              smoother_clear;

    assign smoother_clear = cmd.clear_all
                         || (cfg_we && (cfg_index == frms_pkg::CFG_SMOOTH_MODE));

    // Oldest ring entry sits ring_count places behind the head.
    always_comb
    begin
        oldest_sum = OLD_W'(ring_head_reg) + OLD_W'(MAX_WINDOW) - OLD_W'(ring_count_reg);
        if (oldest_sum >= OLD_W'(MAX_WINDOW))
        begin
            oldest = HEAD_W'(oldest_sum - OLD_W'(MAX_WINDOW));
        end
        else
        begin
            oldest = HEAD_W'(oldest_sum);
        end
    end

    // Window zero counts as one; a window past the ring depth saturates.
    always_comb
    begin
        win_ext = CMP_W'(avg_window_reg);
        if (win_ext == '0)
        begin
            win_eff = CMP_W'(1);
        end
        else if (win_ext > CMP_W'(MAX_WINDOW))
        begin
            win_eff = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = win_ext;
        end
    end

    // Restoring division, one quotient bit per step.
    assign trial      = {rem_reg, dq_reg[SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, dvs_reg});
    assign trial_diff = trial - {1'b0, dvs_reg};

    // One multiplier shared by both products of the low-pass update.
    always_comb
    begin
        if (cmd.mul2)
        begin
            mul_a = raw_reg;
            mul_b = (COEFF_W + 1)'(1 << COEFF_W) - {1'b0, lp_coeff_reg};
        end
        else
        begin
            mul_a = filter_value_reg;
            mul_b = {1'b0, lp_coeff_reg};
        end
        prod   = ACC_W'(mul_a) * ACC_W'(mul_b);
        lp_sum = acc_reg + prod;
    end

    // Control and smoother state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_mode_reg   <= frms_pkg::MODE_NONE;
            lp_coeff_reg      <= frms_pkg::LP_COEFF_RST;
            avg_window_reg    <= frms_pkg::AVG_WINDOW_RST;
            last_stamp_reg    <= '0;
            filter_value_reg  <= '0;
            filter_seeded_reg <= 1'b0;
            ring_head_reg     <= '0;
            ring_count_reg    <= '0;
            ring_sum_reg      <= '0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    frms_pkg::CFG_SMOOTH_MODE: smooth_mode_reg <= cfg_data[MODE_W-1:0];
                    frms_pkg::CFG_LP_COEFF:    lp_coeff_reg    <= cfg_data[COEFF_W-1:0];
                    frms_pkg::CFG_AVG_WINDOW:  avg_window_reg  <= cfg_data[WIN_W-1:0];
                    default:                   ;
                endcase
            end

            if (cmd.clear_all)
            begin
                last_stamp_reg <= '0;
            end
            else if (cmd.stamp_store)
            begin
                last_stamp_reg <= now_reg;
            end

            if (smoother_clear)
            begin
                filter_value_reg  <= '0;
                filter_seeded_reg <= 1'b0;
                ring_head_reg     <= '0;
                ring_count_reg    <= '0;
                ring_sum_reg      <= '0;
            end
            else
            begin
                if (cmd.seed)
                begin
                    filter_value_reg  <= raw_reg;
                    filter_seeded_reg <= 1'b1;
                end
                if (cmd.mul2)
                begin
                    filter_value_reg <= lp_sum[COEFF_W +: RATE_W];
                end
                if (cmd.ev_sub)
                begin
                    ring_sum_reg   <= ring_sum_reg - SUM_W'(ram_rdata);
                    ring_count_reg <= ring_count_reg - CNT_W'(1);
                end
                if (cmd.ins)
                begin
                    ring_sum_reg   <= ring_sum_reg + SUM_W'(raw_reg);
                    ring_count_reg <= ring_count_reg + CNT_W'(1);
                    if (ring_head_reg == HEAD_W'(MAX_WINDOW - 1))
                    begin
                        ring_head_reg <= '0;
                    end
                    else
                    begin
                        ring_head_reg <= ring_head_reg + HEAD_W'(1);
                    end
                end
            end

            if (cmd.div1_load || cmd.div2_load)
            begin
                div_cnt_reg <= DCNT_W'(SUM_W);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= req_type;
            now_reg <= frame_time;
        end

        if (cmd.div1_load)
        begin
            dq_reg  <= SUM_W'(frms_pkg::RATE_SCALE);
            rem_reg <= '0;
            dvs_reg <= now_reg - last_stamp_reg;
        end
        else if (cmd.div2_load)
        begin
            dq_reg  <= ring_sum_reg;
            rem_reg <= '0;
            dvs_reg <= STAMP_W'(ring_count_reg);
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
        end

        if (cmd.mul1)
        begin
            acc_reg <= prod;
        end

        if (cmd.res_zero)
        begin
            raw_reg <= '0;
            sm_reg  <= '0;
            ok_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.raw_load)
            begin
                raw_reg <= dq_reg[RATE_W-1:0];
                ok_reg  <= 1'b1;
            end
            if (cmd.sm_raw || cmd.seed)
            begin
                sm_reg <= raw_reg;
            end
            if (cmd.mul2)
            begin
                sm_reg <= lp_sum[COEFF_W +: RATE_W];
            end
            if (cmd.sm_quot)
            begin
                sm_reg <= dq_reg[RATE_W-1:0];
            end
        end

        if (cmd.out_load)
        begin
            out_raw_reg <= raw_reg;
            out_sm_reg  <= sm_reg;
            out_ok_reg  <= ok_reg;
        end
    end

    frms_ram #(
        .WIDTH (RATE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.ins),
        .waddr (ring_head_reg),
        .wdata (raw_reg),
        .re    (cmd.ev_rd),
        .raddr (oldest),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.req_clear    = (req_reg == frms_pkg::REQ_CLEAR);
        sts.interval_ok  = (last_stamp_reg != '0) && (last_stamp_reg < now_reg);
        sts.div_done     = (div_cnt_reg == '0);
        sts.mode         = smooth_mode_reg;
        sts.seeded       = filter_seeded_reg;
        sts.evict_needed = (CMP_W'(ring_count_reg) >= win_eff);
    end

    assign raw_rate      = out_raw_reg;
    assign smoothed_rate = out_sm_reg;
    assign rate_valid    = out_ok_reg;

endmodule

`default_nettype wire

@@ src/frms_ctrl.sv @@
// Controller: sequences one item through division, smoothing and the output register.
`timescale 1ns / 1ps
`default_nettype none

module frms_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire frms_pkg::sts_t sts,
    output frms_pkg::cmd_t      cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECIDE = 11'b000_0000_0010,
        S_DIV1   = 11'b000_0000_0100,
        S_SMOOTH = 11'b000_0000_1000,
        S_MUL1   = 11'b000_0001_0000,
        S_MUL2   = 11'b000_0010_0000,
        S_EVRD   = 11'b000_0100_0000,
        S_EVSUB  = 11'b000_1000_0000,
        S_AVGLD  = 11'b001_0000_0000,
        S_DIV2   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.req_clear)
                begin
                    cmd.clear_all = 1'b1;
                    cmd.res_zero  = 1'b1;
                    state_next    = S_DONE;
                end
                else if (!sts.interval_ok)
                begin
                    cmd.stamp_store = 1'b1;
                    cmd.res_zero    = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.stamp_store = 1'b1;
                    cmd.div1_load   = 1'b1;
                    state_next      = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                begin
                    cmd.raw_load = 1'b1;
                    state_next   = S_SMOOTH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_SMOOTH:
            begin
                if (sts.mode == frms_pkg::MODE_LP)
                begin
                    if (sts.seeded)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        cmd.seed   = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (sts.mode == frms_pkg::MODE_AVG)
                begin
                    state_next = S_EVRD;
                end
                else
                begin
                    cmd.sm_raw = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DONE;
            end
            S_EVRD:
            begin
                if (sts.evict_needed)
                begin
                    cmd.ev_rd  = 1'b1;
                    state_next = S_EVSUB;
                end
                else
                begin
                    cmd.ins    = 1'b1;
                    state_next = S_AVGLD;
                end
            end
            S_EVSUB:
            begin
                cmd.ev_sub = 1'b1;
                state_next = S_EVRD;
            end
            S_AVGLD:
            begin
                cmd.div2_load = 1'b1;
                state_next    = S_DIV2;
            end
            S_DIV2:
            begin
                if (sts.div_done)
                begin
                    cmd.sm_quot = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/frame_rate_meter_smoothed.sv @@
// A clear beat or a mark without a usable interval goes straight from the decide state to the
// done state. A mark with a usable interval first runs the bit-serial divider for W quotient
// bits (W = 18 + ceil(log2 MAX_WINDOW), 22 by default), then the low-pass multiply steps or,
// with the moving average, the evictions (usually one), the insert and a second W-bit division.
// Throughput: one beat at a time; the next beat can be taken as soon as the result is offered.
// Reset: asynchronous, active low; state and config registers reset, data and ring do not.
`timescale 1ns / 1ps
`default_nettype none

module frame_rate_meter_smoothed #(
    parameter int MAX_WINDOW = frms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Input beats: frame marks and clear requests.
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic [frms_pkg::STAMP_W-1:0]      frame_time,

    // Result beats: one per input beat.
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [frms_pkg::RATE_W-1:0]       raw_rate,
    output logic      [frms_pkg::RATE_W-1:0]       smoothed_rate,
    output logic                                   rate_valid,

    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [frms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [frms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    frms_pkg::cmd_t cmd;
    frms_pkg::sts_t sts;

    // Register writes go straight into the configuration registers, so the write channel never holds off.
    assign cfg_ready = 1'b1;

    // The controller walks each beat through the stamp check and, for a mark with a usable
    // interval, the division for the raw rate and the selected smoother, and finally the output
    // register. The output register lets the controller return to idle and take the next beat
    // while the previous result still waits downstream.
    frms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the previous stamp, the configuration registers, the filter
    // state and the averaging ring with its running sum. One restoring divider serves
    // both the raw rate and the average, and one multiplier serves both products of
    // the low-pass update.
    frms_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .frame_time    (frame_time),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .raw_rate      (raw_rate),
        .smoothed_rate (smoothed_rate),
        .rate_valid    (rate_valid)
    );

endmodule

`default_nettype wire
